// File: src/neighbor_difference_edge_map_macros.svh
// Assertion helpers shared by the edge map modules.
`ifndef NEIGHBOR_DIFFERENCE_EDGE_MAP_MACROS_SVH
`define NEIGHBOR_DIFFERENCE_EDGE_MAP_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define NDE_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define NDE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: src/nde_pkg.sv
`default_nettype none

package nde_pkg;

    // Field widths
    localparam int PIX_W  = 8;
    localparam int SUM_W  = 10;
    localparam int X_W    = 10;
    localparam int Y_W    = 12;
    localparam int INT_W  = 8;
    localparam int FW_W   = 11;
    localparam int FH_W   = 13;
    localparam int IN_W   = 24;
    localparam int OUT_W  = 32;

    // Configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 13;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 2'd1;

    localparam logic [FW_W-1:0] FW_RESET   = 11'd1024;
    localparam logic [FH_W-1:0] FH_RESET   = 13'd1024;
    localparam logic [FH_W-1:0] MAX_HEIGHT = 13'd4096;

    // Queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;
    localparam int QCNT_W      = 3;
    localparam int OCC_W       = QCNT_W + 1;

    // Result slots, in emission order
    localparam int RES_N  = 4;
    localparam int RES_UL = 0;   // (x-1, y-1): all four neighbors known
    localparam int RES_UP = 1;   // (x, y-1): last column of the row above
    localparam int RES_LF = 2;   // (x-1, y): bottom row
    localparam int RES_HR = 3;   // (x, y): bottom-right corner

    // Neighbor offsets
    localparam logic signed [2:0] OFF_RIGHT = -3'sd1;
    localparam logic signed [2:0] OFF_DOWN  = -3'sd1;
    localparam logic signed [2:0] OFF_DR    = -3'sd2;
    localparam logic signed [2:0] OFF_DL    = 3'sd0;

    typedef struct packed {
        logic [X_W-1:0]   x;
        logic [Y_W-1:0]   y;
        logic [SUM_W-1:0] s;
        logic [SUM_W-1:0] p1;
        logic [SUM_W-1:0] p2;
        logic [SUM_W-1:0] up_x;
        logic [SUM_W-1:0] up_xm1;
        logic [RES_N-1:0] res_mask;
        logic             use_p2;
    } t_item;

    typedef struct packed {
        logic  valid;
        t_item item;
    } t_slot;

    // (5 * |a - b + off|) mod 256
    function automatic logic [INT_W-1:0] edge_term(
        input logic [SUM_W-1:0] a,
        input logic [SUM_W-1:0] b,
        input logic signed [2:0] off
    );
        logic signed [11:0] d;
        logic [10:0]        mag;
        logic [7:0]         lo;
        d   = $signed({2'b00, a}) - $signed({2'b00, b}) + $signed({{9{off[2]}}, off});
        mag = d[11] ? 11'(-d) : d[10:0];
        lo  = mag[7:0];
        return lo + {lo[5:0], 2'b00};
    endfunction

endpackage

`default_nettype wire

// File: src/nde_ram.sv
`default_nettype none

module nde_ram #(
    parameter int WIDTH = 10,
    parameter int DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Read-first: a read at the write address returns the old word
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// File: src/nde_front.sv
`default_nettype none
`include "neighbor_difference_edge_map_macros.svh"

module nde_front
    import nde_pkg::*;
#(
    parameter int MAX_WIDTH = 1024
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic                  i_tvalid,
    output logic                       o_tready,
    input  wire logic [IN_W-1:0]       i_tdata,
    input  wire logic [QCNT_W-1:0]     i_q_count,
    output t_slot                      o_push
);

    localparam int XW = (MAX_WIDTH > 2) ? $clog2(MAX_WIDTH) : 1;

    logic [FW_W-1:0]  r_frame_width;
    logic [FH_W-1:0]  r_frame_height;
    logic [XW-1:0]    r_x, n_x;
    logic [Y_W-1:0]   r_y, n_y;
    logic [SUM_W-1:0] r_p1, r_p2;
    logic             r_s1_valid;
    t_item            r_s1;
    logic [SUM_W-1:0] r_up_hold;

    logic [XW-1:0]    w_last;
    logic [Y_W-1:0]   h_last;
    logic [OCC_W-1:0] occ;
    logic             accept;
    logic             restart;
    logic [SUM_W-1:0] s;
    logic [SUM_W-1:0] ram_rdata;
    logic             x_ge1, x_end, y_ge1, y_end;

    // Effective frame size, saturated
    always_comb begin
        if (r_frame_width < 11'd2) begin
            w_last = XW'(1);
        end else if (32'(r_frame_width) > MAX_WIDTH) begin
            w_last = XW'(MAX_WIDTH - 1);
        end else begin
            w_last = XW'(r_frame_width - 11'd1);
        end
        if (r_frame_height < 13'd2) begin
            h_last = 12'd1;
        end else if (r_frame_height > MAX_HEIGHT) begin
            h_last = 12'd4095;
        end else begin
            h_last = 12'(r_frame_height - 13'd1);
        end
    end

    // Room for this word and the one in the staging register
    assign occ      = {1'b0, i_q_count} + OCC_W'(r_s1_valid);
    assign o_tready = occ < OCC_W'(QUEUE_DEPTH);
    assign accept   = i_tvalid & o_tready;
    assign restart  = i_cfg_we &
                      ((i_cfg_idx == CFG_FRAME_WIDTH) || (i_cfg_idx == CFG_FRAME_HEIGHT));

    assign s = SUM_W'(i_tdata[7:0]) + SUM_W'(i_tdata[15:8]) + SUM_W'(i_tdata[23:16]);

    assign x_ge1 = (r_x != '0);
    assign x_end = (r_x == w_last);
    assign y_ge1 = (r_y != '0);
    assign y_end = (r_y == h_last);

    // Line buffer: read the row above at x, then overwrite it with this row
    nde_ram #(
        .WIDTH(SUM_W),
        .DEPTH(MAX_WIDTH)
    ) u_line (
        .i_clk  (i_clk),
        .i_we   (accept),
        .i_waddr(r_x),
        .i_wdata(s),
        .i_re   (accept),
        .i_raddr(r_x),
        .o_rdata(ram_rdata)
    );

    // Raster position
    always_comb begin
        n_x = r_x;
        n_y = r_y;
        priority if (restart) begin
            n_x = '0;
            n_y = '0;
        end else if (accept) begin
            if (x_end) begin
                n_x = '0;
                n_y = y_end ? '0 : r_y + 12'd1;
            end else begin
                n_x = r_x + XW'(1);
            end
        end
    end

    // Control and configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= FW_RESET;
            r_frame_height <= FH_RESET;
            r_x            <= '0;
            r_y            <= '0;
            r_p1           <= '0;
            r_p2           <= '0;
            r_s1_valid     <= 1'b0;
        end else begin
            if (i_cfg_we && (i_cfg_idx == CFG_FRAME_WIDTH)) begin
                r_frame_width <= i_cfg_data[FW_W-1:0];
            end
            if (i_cfg_we && (i_cfg_idx == CFG_FRAME_HEIGHT)) begin
                r_frame_height <= i_cfg_data;
            end
            r_x        <= n_x;
            r_y        <= n_y;
            r_s1_valid <= accept;
            if (restart) begin
                r_p1 <= '0;
                r_p2 <= '0;
            end else if (accept) begin
                r_p1 <= s;
                r_p2 <= r_p1;
            end
        end
    end

    // Staging register: holds the pixel while the registered line buffer read completes
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1.x                <= X_W'(r_x);
            r_s1.y                <= r_y;
            r_s1.s                <= s;
            r_s1.p1               <= r_p1;
            r_s1.p2               <= r_p2;
            r_s1.up_x             <= '0;
            r_s1.up_xm1           <= '0;
            r_s1.res_mask[RES_UL] <= y_ge1 & x_ge1;
            r_s1.res_mask[RES_UP] <= y_ge1 & x_end;
            r_s1.res_mask[RES_LF] <= y_end & x_ge1;
            r_s1.res_mask[RES_HR] <= y_end & x_end;
            r_s1.use_p2           <= (r_x > XW'(1));
        end
        // Row-above word at x becomes the one at x-1 for the next pixel
        if (r_s1_valid) begin
            r_up_hold <= ram_rdata;
        end
    end

    always_comb begin
        o_push             = '{valid: r_s1_valid, item: r_s1};
        o_push.item.up_x   = ram_rdata;
        o_push.item.up_xm1 = r_up_hold;
    end

    `NDE_ASSERT_NOW(a_x_in_row, i_clk, i_rst_n, 1'b1, r_x <= w_last, "column past row end")
    `NDE_ASSERT_NOW(a_y_in_frame, i_clk, i_rst_n, 1'b1, r_y <= h_last, "row past frame end")

endmodule

`default_nettype wire

// File: src/nde_queue.sv
`default_nettype none
`include "neighbor_difference_edge_map_macros.svh"

module nde_queue
    import nde_pkg::*;
(
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire t_slot         i_push,
    output logic [QCNT_W-1:0]  o_count,
    output t_slot              o_head,
    input  wire logic          i_pop
);

    t_item             r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wp, r_rp;
    logic [QCNT_W-1:0] r_count;

    // Storage
    always_ff @(posedge i_clk) begin
        if (i_push.valid) begin
            r_mem[r_wp] <= i_push.item;
        end
    end

    // Pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            if (i_push.valid) begin
                r_wp <= r_wp + QPTR_W'(1);
            end
            if (i_pop) begin
                r_rp <= r_rp + QPTR_W'(1);
            end
            r_count <= r_count + QCNT_W'(i_push.valid) - QCNT_W'(i_pop);
        end
    end

    assign o_count = r_count;
    assign o_head  = '{valid: (r_count != '0), item: r_mem[r_rp]};

    `NDE_ASSERT_NOW(a_no_overflow, i_clk, i_rst_n, i_push.valid,
        r_count < QCNT_W'(QUEUE_DEPTH), "push into full queue")
    `NDE_ASSERT_NOW(a_no_underflow, i_clk, i_rst_n, i_pop, r_count != '0, "pop from empty queue")

endmodule

`default_nettype wire

// File: src/nde_back.sv
`default_nettype none
`include "neighbor_difference_edge_map_macros.svh"

module nde_back
    import nde_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire t_slot            i_head,
    output logic                  o_pop,
    output logic                  o_tvalid,
    input  wire logic             i_tready,
    output logic [OUT_W-1:0]      o_tdata,
    output logic                  o_tlast
);

    logic [RES_N-1:0] r_done;
    logic             r_ovalid;
    logic [OUT_W-1:0] r_odata;
    logic             r_olast;

    t_item            it;
    logic [RES_N-1:0] rem, sel;
    logic             sel_last;
    logic             can_load;
    logic [X_W-1:0]   res_x;
    logic [Y_W-1:0]   res_y;
    logic [INT_W-1:0] res_v;
    logic [INT_W-1:0] t_dl;

    assign it       = i_head.item;
    assign rem      = it.res_mask & ~r_done;
    assign sel      = rem & (~rem + RES_N'(1));
    assign sel_last = ((rem & ~sel) == '0);
    assign can_load = !r_ovalid || i_tready;

    // Down-left neighbor only exists two columns in
    assign t_dl = it.use_p2 ? edge_term(it.up_xm1, it.p2, OFF_DL) : '0;

    // Pick the earliest pending result and form its word
    always_comb begin
        res_x = it.x;
        res_y = it.y;
        res_v = '0;
        priority if (rem[RES_UL]) begin
            res_x = it.x - X_W'(1);
            res_y = it.y - Y_W'(1);
            res_v = edge_term(it.up_xm1, it.up_x, OFF_RIGHT)
                  + edge_term(it.up_xm1, it.p1, OFF_DOWN)
                  + edge_term(it.up_xm1, it.s, OFF_DR)
                  + t_dl;
        end else if (rem[RES_UP]) begin
            res_y = it.y - Y_W'(1);
            res_v = edge_term(it.up_x, it.s, OFF_DOWN) + edge_term(it.up_x, it.p1, OFF_DL);
        end else if (rem[RES_LF]) begin
            res_x = it.x - X_W'(1);
            res_v = edge_term(it.p1, it.s, OFF_RIGHT);
        end else begin
            res_v = '0;
        end
    end

    // Sequencing over one queue word; output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done   <= '0;
            r_ovalid <= 1'b0;
        end else if (can_load) begin
            r_ovalid <= i_head.valid && (rem != '0);
            if (i_head.valid && !sel_last) begin
                r_done <= r_done | sel;
            end else begin
                r_done <= '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (can_load) begin
            r_odata <= {{(OUT_W - INT_W - Y_W - X_W){1'b0}}, res_v, res_y, res_x};
            r_olast <= sel_last;
        end
    end

    // A word only leaves the queue once all its results are out
    assign o_pop    = i_head.valid && can_load && sel_last;
    assign o_tvalid = r_ovalid;
    assign o_tdata  = r_odata;
    assign o_tlast  = r_olast;

    `NDE_ASSERT_NOW(a_done_has_head, i_clk, i_rst_n, r_done != '0, i_head.valid,
        "partial results without a queued word")
    `NDE_ASSERT_NOW(a_done_in_mask, i_clk, i_rst_n, r_done != '0,
        (r_done & ~i_head.item.res_mask) == '0, "emitted result not in word")

endmodule

`default_nettype wire

// File: src/neighbor_difference_edge_map.sv
// Channel   Dir  Handshake                 Payload
// s_axis    in   tvalid/tready             tdata: blue[7:0] green[15:8] red[23:16]
// m_axis    out  tvalid/tready             tdata: out_x[9:0] out_y[21:10] intensity[29:22];
//                                          tlast: last_of_run
// cfg       in   we (no wait)              idx 0 frame_width, idx 1 frame_height
//
// One pixel per clock is accepted while the queue has room; results leave one per
// clock while m_axis is ready, one pixel's results in turn (none still takes a turn).
// Results pass through the line buffer read, the queue and the output register.
// A four-word queue sits between front and back; the front stops taking pixels
// only when the queue plus its staging register would be full.
// Synchronous active-low reset clears counters, queue and output; the line buffer
// is not cleared since results of the first row of a frame never use what it reads.
`default_nettype none

module neighbor_difference_edge_map
    import nde_pkg::*;
#(
    parameter int MAX_WIDTH = 1024
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic                  i_s_axis_tvalid,
    output logic                       o_s_axis_tready,
    input  wire logic [IN_W-1:0]       i_s_axis_tdata,  // blue, green, red
    output logic                       o_m_axis_tvalid,
    input  wire logic                  i_m_axis_tready,
    output logic [OUT_W-1:0]           o_m_axis_tdata,  // out_x, out_y, intensity
    output logic                       o_m_axis_tlast
);

    t_slot             push;
    t_slot             head;
    logic [QCNT_W-1:0] q_count;
    logic              pop;

    nde_front #(
        .MAX_WIDTH(MAX_WIDTH)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg_we  (i_cfg_we),
        .i_cfg_idx (i_cfg_idx),
        .i_cfg_data(i_cfg_data),
        .i_tvalid  (i_s_axis_tvalid),
        .o_tready  (o_s_axis_tready),
        .i_tdata   (i_s_axis_tdata),
        .i_q_count (q_count),
        .o_push    (push)
    );

    nde_queue u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (push),
        .o_count(q_count),
        .o_head (head),
        .i_pop  (pop)
    );

    nde_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_head  (head),
        .o_pop   (pop),
        .o_tvalid(o_m_axis_tvalid),
        .i_tready(i_m_axis_tready),
        .o_tdata (o_m_axis_tdata),
        .o_tlast (o_m_axis_tlast)
    );

endmodule

`default_nettype wire
